// File: design/nvp_pkg.sv
// Shared types, character codes and classification functions for the name/value tokenizer.
package nvp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned RoleW = 2;

  typedef logic [CharW-1:0] char_t;

  typedef enum logic [2:0] {
    MODE_SEEK_NAME   = 3'd0,
    MODE_IN_NAME     = 3'd1,
    MODE_SEEK_EQ     = 3'd2,
    MODE_SEEK_VALUE  = 3'd3,
    MODE_IN_QUOTED   = 3'd4,
    MODE_IN_UNQUOTED = 3'd5,
    MODE_FAILED      = 3'd6
  } mode_t;

  typedef enum logic [RoleW-1:0] {
    ROLE_SKIP  = 2'd0,
    ROLE_NAME  = 2'd1,
    ROLE_VALUE = 2'd2
  } role_t;

  localparam char_t CH_END    = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_EQ     = 8'h3D;

  typedef struct packed {
    logic [RoleW-1:0] role;
    logic             pair_done;
    logic             parse_failed;
    logic             string_end;
  } result_t;

  function automatic logic is_sep(input char_t c);
    return c inside {CH_COMMA, CH_SEMI, CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_quote(input char_t c);
    return c inside {CH_SQUOTE, CH_DQUOTE};
  endfunction

endpackage

// File: design/nvp_in_stage.sv
// Input register: captures one character per transaction and hands it to the parser.
module nvp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nvp_pkg::char_t in_ch,
  output logic           stg_valid,
  input  logic           stg_take,
  output nvp_pkg::char_t stg_ch
);
  import nvp_pkg::*;

  logic  valid_r;
  char_t ch_r;

  // Free slot, or the held character leaves this cycle.
  assign in_ready  = !valid_r || stg_take;
  assign stg_valid = valid_r;
  assign stg_ch    = ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

endmodule

// File: design/nvp_parser.sv
// Parse state machine: tags one character and advances the mode on each step.
module nvp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  nvp_pkg::char_t   ch,
  output nvp_pkg::result_t res
);
  import nvp_pkg::*;

  mode_t mode_r, mode_nxt;
  logic  dq_r, dq_nxt;

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    dq_nxt   = dq_r;
    if (ch == CH_END) begin
      mode_nxt = MODE_SEEK_NAME;
      dq_nxt   = 1'b0;
    end else begin
      case (mode_r)
        MODE_IN_NAME: begin
          if (ch == CH_EQ) begin
            mode_nxt = MODE_SEEK_VALUE;
          end else if (is_sep(ch)) begin
            mode_nxt = MODE_SEEK_EQ;
          end
        end
        MODE_SEEK_EQ: begin
          if (ch == CH_EQ) begin
            mode_nxt = MODE_SEEK_VALUE;
          end else if (!is_sep(ch)) begin
            mode_nxt = MODE_FAILED;
          end
        end
        MODE_SEEK_VALUE: begin
          if (is_sep(ch)) begin
            mode_nxt = MODE_SEEK_VALUE;
          end else if (is_quote(ch)) begin
            dq_nxt   = (ch == CH_DQUOTE);
            mode_nxt = MODE_IN_QUOTED;
          end else if (ch == CH_EQ) begin
            mode_nxt = MODE_SEEK_NAME;
          end else begin
            mode_nxt = MODE_IN_UNQUOTED;
          end
        end
        MODE_IN_QUOTED: begin
          if (ch == (dq_r ? CH_DQUOTE : CH_SQUOTE)) begin
            mode_nxt = MODE_SEEK_NAME;
          end
        end
        MODE_IN_UNQUOTED: begin
          if (ch == CH_EQ || is_sep(ch)) begin
            mode_nxt = MODE_SEEK_NAME;
          end
        end
        MODE_FAILED: begin
          mode_nxt = MODE_FAILED;
        end
        default: begin
          if (ch == CH_EQ) begin
            mode_nxt = MODE_SEEK_VALUE;
          end else if (is_sep(ch)) begin
            mode_nxt = MODE_SEEK_NAME;
          end else begin
            mode_nxt = MODE_IN_NAME;
          end
        end
      endcase
    end
  end

  // Outputs.
  always_comb begin
    res = '{role: ROLE_SKIP, pair_done: 1'b0, parse_failed: 1'b0, string_end: 1'b0};
    if (ch == CH_END) begin
      res.string_end = 1'b1;
      case (mode_r)
        MODE_SEEK_VALUE, MODE_IN_QUOTED, MODE_IN_UNQUOTED: res.pair_done = 1'b1;
        MODE_FAILED:                                       res.pair_done = 1'b0;
        default:                                           res.parse_failed = 1'b1;
      endcase
    end else begin
      case (mode_r)
        MODE_IN_NAME: begin
          if (ch != CH_EQ && !is_sep(ch)) begin
            res.role = ROLE_NAME;
          end
        end
        MODE_SEEK_EQ: begin
          res.parse_failed = (ch != CH_EQ) && !is_sep(ch);
        end
        MODE_SEEK_VALUE: begin
          if (ch == CH_EQ) begin
            res.pair_done = 1'b1;
          end else if (!is_sep(ch) && !is_quote(ch)) begin
            res.role = ROLE_VALUE;
          end
        end
        MODE_IN_QUOTED: begin
          if (ch == (dq_r ? CH_DQUOTE : CH_SQUOTE)) begin
            res.pair_done = 1'b1;
          end else begin
            res.role = ROLE_VALUE;
          end
        end
        MODE_IN_UNQUOTED: begin
          if (ch == CH_EQ || is_sep(ch)) begin
            res.pair_done = 1'b1;
          end else begin
            res.role = ROLE_VALUE;
          end
        end
        MODE_FAILED: begin
          res.role = ROLE_SKIP;
        end
        default: begin
          if (ch != CH_EQ && !is_sep(ch)) begin
            res.role = ROLE_NAME;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SEEK_NAME;
      dq_r   <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
    end
  end

  a_done_xor_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.pair_done && res.parse_failed))
    else $error("pair_done and parse_failed both set");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && ch == CH_END |=> mode_r == MODE_SEEK_NAME && !dq_r)
    else $error("end marker did not return parser to start");

  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_FAILED && ch != CH_END |->
      res.role == ROLE_SKIP && !res.pair_done && !res.parse_failed)
    else $error("failed mode produced a tag or flag");

  a_fail_enters_failed: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.parse_failed && !res.string_end |=> mode_r == MODE_FAILED)
    else $error("mid-string failure did not latch failed mode");

endmodule

// File: design/nvp_out_stage.sv
// Result register: holds one tagged character until the consumer takes it.
module nvp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  nvp_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output nvp_pkg::result_t out_res
);
  import nvp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

// File: design/name_value_pair_tokenizer.sv
// Top level of the name/value pair tokenizer: input register, parser, result register.
//
// Feed one character per transaction on the in_ channel; each character yields exactly one
// result transaction on the out_ channel carrying its role (0 skipped or delimiter, 1 name,
// 2 value), pair_done on the character that closes a pair, parse_failed where parsing stops
// without a further pair, and string_end on the byte 0 that ends the string, after which the
// parser is back at its start. Throughput is one character per clock cycle, sustained while
// out_ready stays high; a character is held in the input register, and its result is written
// into the result register when the parser steps on it. The rate is set by the parse mode
// register, whose next value is a short function of the current mode and one character.
// in_ready depends combinationally on out_ready through the two register stages. There are
// no configuration registers and no setup after reset.
module name_value_pair_tokenizer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_ch,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_role,
  output logic                    out_pair_done,
  output logic                    out_parse_failed,
  output logic                    out_string_end
);
  import nvp_pkg::*;

  logic    stg_valid;
  logic    stg_take;
  char_t   stg_ch;
  logic    res_ready;
  result_t res;
  result_t out_res;

  // Hold the incoming character until the parser can step on it.
  nvp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .stg_valid (stg_valid),
    .stg_take  (stg_take),
    .stg_ch    (stg_ch)
  );

  // Advance the parser only when its result is written into the result register.
  assign stg_take = stg_valid && res_ready;

  nvp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (stg_take),
    .ch    (stg_ch),
    .res   (res)
  );

  nvp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (stg_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_role         = out_res.role;
  assign out_pair_done    = out_res.pair_done;
  assign out_parse_failed = out_res.parse_failed;
  assign out_string_end   = out_res.string_end;

endmodule

// File: dv/tb_name_value_pair_tokenizer.sv
// Testbench for the name/value pair tokenizer: character streams in, checked role/flag results out.
`timescale 1ns / 1ps

module tb_name_value_pair_tokenizer;
  import nvp_pkg::*;

  // Accepted transactions per idling phase; the third phase runs with no idling.
  localparam int unsigned PHASE_LEN    = 450;
  // Accepted-transaction count at which the receiver starts its long hold-off.
  localparam int unsigned HOLD_AT      = 1000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = CH_END;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_role;
  logic       out_pair_done;
  logic       out_parse_failed;
  logic       out_string_end;

  // Characters waiting to be offered, and results owed by the tokenizer, oldest first.
  char_t       pending_chars[$];
  result_t     expected_results[$];

  // Shadow copy of the parser state, advanced once per accepted character.
  mode_t       shadow_mode = MODE_SEEK_NAME;
  logic        shadow_dquote = 1'b0;

  int unsigned n_sent = 0;
  int unsigned n_errors = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  name_value_pair_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_role         (out_role),
    .out_pair_done    (out_pair_done),
    .out_parse_failed (out_parse_failed),
    .out_string_end   (out_string_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tokenizer prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_separator(input char_t c);
    case (c)
      CH_COMMA, CH_SEMI, CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Advance the shadow parser by one character and return the result it owes.
  function automatic result_t tokenize_char(input char_t c);
    result_t r;
    char_t   closer;
    r = '0;
    closer = shadow_dquote ? CH_DQUOTE : CH_SQUOTE;
    if (c == CH_END) begin
      // End of string: close an open value, flag an end outside any value unless already failed, then restart.
      r.string_end = 1'b1;
      case (shadow_mode)
        MODE_SEEK_VALUE, MODE_IN_QUOTED, MODE_IN_UNQUOTED: r.pair_done = 1'b1;
        MODE_FAILED: ;
        default: r.parse_failed = 1'b1;
      endcase
      shadow_mode = MODE_SEEK_NAME;
      shadow_dquote = 1'b0;
    end else begin
      case (shadow_mode)
        MODE_IN_NAME: begin
          if (c == CH_EQ) shadow_mode = MODE_SEEK_VALUE;
          else if (is_separator(c)) shadow_mode = MODE_SEEK_EQ;
          else r.role = ROLE_NAME;
        end
        MODE_SEEK_EQ: begin
          // Only separators may stand between a name and its '='.
          if (c == CH_EQ) begin
            shadow_mode = MODE_SEEK_VALUE;
          end else if (!is_separator(c)) begin
            r.parse_failed = 1'b1;
            shadow_mode = MODE_FAILED;
          end
        end
        MODE_SEEK_VALUE: begin
          if (is_separator(c)) begin
            // skip leading separators
          end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            shadow_dquote = (c == CH_DQUOTE);
            shadow_mode = MODE_IN_QUOTED;
          end else if (c == CH_EQ) begin
            // A second '=' closes a pair with an empty value.
            r.pair_done = 1'b1;
            shadow_mode = MODE_SEEK_NAME;
          end else begin
            r.role = ROLE_VALUE;
            shadow_mode = MODE_IN_UNQUOTED;
          end
        end
        MODE_IN_QUOTED: begin
          if (c == closer) begin
            r.pair_done = 1'b1;
            shadow_mode = MODE_SEEK_NAME;
          end else begin
            r.role = ROLE_VALUE;
          end
        end
        MODE_IN_UNQUOTED: begin
          if (c == CH_EQ || is_separator(c)) begin
            r.pair_done = 1'b1;
            shadow_mode = MODE_SEEK_NAME;
          end else begin
            r.role = ROLE_VALUE;
          end
        end
        MODE_FAILED: ;
        default: begin
          // Seeking a name; a bare '=' starts a pair with an empty name.
          if (c == CH_EQ) begin
            shadow_mode = MODE_SEEK_VALUE;
          end else if (!is_separator(c)) begin
            r.role = ROLE_NAME;
            shadow_mode = MODE_IN_NAME;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic char_t sep_char();
    case ($urandom_range(0, 5))
      0: return CH_COMMA;
      1: return CH_SEMI;
      2: return CH_SPACE;
      3: return CH_TAB;
      4: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Any nonzero byte that neither separates nor assigns; quotes allowed.
  function automatic char_t name_char();
    char_t c;
    do c = char_t'($urandom_range(1, 255));
    while (is_separator(c) || c == CH_EQ);
    return c;
  endfunction

  function automatic char_t bare_value_char();
    char_t c;
    do c = name_char();
    while (c == CH_SQUOTE || c == CH_DQUOTE);
    return c;
  endfunction

  // Append one name=value pair; set cut when the value was left open for the end marker.
  task automatic add_pair(output bit cut);
    char_t quote;
    char_t c;
    int    kind;
    repeat ($urandom_range(0, 2)) pending_chars.push_back(sep_char());
    repeat ($urandom_range(0, 4)) pending_chars.push_back(name_char());
    if ($urandom_range(0, 3) == 0) pending_chars.push_back(sep_char());
    pending_chars.push_back(CH_EQ);
    repeat ($urandom_range(0, 2)) pending_chars.push_back(sep_char());
    kind = $urandom_range(0, 5);
    cut = ($urandom_range(0, 7) == 0);
    case (kind)
      0: if (!cut) pending_chars.push_back(CH_EQ);
      1, 2: begin
        repeat ($urandom_range(1, 4)) pending_chars.push_back(bare_value_char());
        if (!cut) pending_chars.push_back($urandom_range(0, 3) == 0 ? CH_EQ : sep_char());
      end
      default: begin
        quote = (kind == 3) ? CH_SQUOTE : CH_DQUOTE;
        pending_chars.push_back(quote);
        repeat ($urandom_range(0, 5)) begin
          do c = char_t'($urandom_range(1, 255));
          while (c == quote);
          pending_chars.push_back(c);
        end
        if (!cut) pending_chars.push_back(quote);
      end
    endcase
  endtask

  // Append one complete string: mostly well-formed pairs, some broken, some noise.
  task automatic add_string();
    int sel;
    int npairs;
    bit cut;
    sel = $urandom_range(0, 15);
    if (sel < 12) begin
      npairs = $urandom_range(1, 4);
      cut = 1'b0;
      while (npairs > 0 && !cut) begin
        add_pair(cut);
        npairs--;
      end
      if (!cut) repeat ($urandom_range(0, 2)) pending_chars.push_back(sep_char());
    end else if (sel == 12) begin
      // Junk after a finished name: fails and then stays failed.
      repeat ($urandom_range(1, 3)) pending_chars.push_back(name_char());
      pending_chars.push_back(sep_char());
      pending_chars.push_back(name_char());
      repeat ($urandom_range(0, 4)) pending_chars.push_back(char_t'($urandom_range(1, 255)));
    end else if (sel == 13) begin
      // Name with no '=' before the end marker.
      repeat ($urandom_range(1, 3)) pending_chars.push_back(name_char());
      if ($urandom_range(0, 1) != 0) pending_chars.push_back(sep_char());
    end else begin
      // Raw bytes, end markers included.
      repeat ($urandom_range(1, 12)) pending_chars.push_back(char_t'($urandom_range(0, 255)));
    end
    pending_chars.push_back(CH_END);
  endtask

  // ---------------------------------------------------------------------------
  // Idling profile: sender/receiver percentages per phase
  // ---------------------------------------------------------------------------

  function automatic int unsigned sender_idle_pct();
    if (n_sent < PHASE_LEN) return 37;
    if (n_sent < 2 * PHASE_LEN) return 88;
    return 0;
  endfunction

  function automatic int unsigned receiver_stall_pct();
    if (n_sent < PHASE_LEN) return 88;
    if (n_sent < 2 * PHASE_LEN) return 37;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer pending characters, hold each until accepted, log the expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch    <= CH_END;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(tokenize_char(in_ch));
        n_sent <= n_sent + 1;
      end
      // Advance only when nothing is on offer or the offer was just taken.
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          in_ch    <= pending_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off that fills the pipeline
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected transaction role=%0d done=%b fail=%b end=%b",
                             out_role, out_pair_done, out_parse_failed, out_string_end));
      end else begin
        want = expected_results.pop_front();
        if (out_role !== want.role)
          flag_error($sformatf("role exp %0d got %0d", want.role, out_role));
        if (out_pair_done !== want.pair_done)
          flag_error($sformatf("pair_done exp %b got %b", want.pair_done, out_pair_done));
        if (out_parse_failed !== want.parse_failed)
          flag_error($sformatf("parse_failed exp %b got %b", want.parse_failed,
                               out_parse_failed));
        if (out_string_end !== want.string_end)
          flag_error($sformatf("string_end exp %b got %b", want.string_end, out_string_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed strings, random strings, reset, drain, verdict
  // ---------------------------------------------------------------------------

  initial begin
    // Directed: empty name with empty value; 0xFF name, separator then '=', single-quoted
    // value holding a double quote; unquoted value closed by '='; unclosed quote at the end;
    // end while seeking a name; end while seeking '='; end right after '='; junk after a
    // name, held failed, then a quiet end.
    pending_chars = '{CH_EQ, CH_EQ,
                      8'hFF, CH_SPACE, CH_EQ, CH_COMMA, CH_SQUOTE, CH_DQUOTE, CH_SQUOTE,
                      "u", CH_EQ, "w", CH_EQ,
                      "p", CH_EQ, CH_DQUOTE, CH_END,
                      CH_END,
                      "q", CH_CR, CH_END,
                      "a", CH_EQ, CH_END,
                      "b", CH_LF, 8'h01, 8'h7F, CH_END};
    while (pending_chars.size() < RANDOM_ITEMS) add_string();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: nothing left to offer, nothing on offer, nothing owed.
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // Keep watching for stray output transactions before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: report an error and stop if the run has not finished by a time far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
